/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: status codes,
// block table entry layout, register indexes and default sizes.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam int ENTRY_W     = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int BCOUNT_W    = 11;
  localparam int ADDR_W      = 32;
  localparam int FIRST_W     = 10;

  localparam logic [ENTRY_W-1:0] ENTRY_TAKEN    = 3'b001;
  localparam logic [ENTRY_W-1:0] ENTRY_FIRST    = 3'b010;
  localparam logic [ENTRY_W-1:0] ENTRY_HAS_NEXT = 3'b100;
  localparam logic [3:0]         TYPE_MASK      = 4'hf;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

  localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_ZERO_SIZE = 2'd2
  } status_t;

  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic logic entry_free(input entry_t e);
    entry_t masked;
    masked = e & TYPE_MASK[ENTRY_W-1:0];
    return (masked & ENTRY_TAKEN) == '0;
  endfunction

endpackage

/* sv/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over a table of fixed-size blocks.
//
// A request is taken at a clock edge with start high and busy low; its size
// in bytes is rounded up to whole blocks and the table is scanned from block
// 0 for the first free run of that length below min(block_count, NUM_BLOCKS).
// The result (status, address, first_block) is on the outputs for exactly one
// cycle with done high; the receiver cannot stall it.
// A zero-size request answers in the cycle after it is taken. Otherwise the scan
// reads one table entry per cycle through the memory read port, at most the
// active block count of them, and on a grant the blocks of the run are marked,
// one per cycle through the write port. busy stays high for the whole request
// unless its size is zero.
// After reset the table is cleared, one entry per cycle over all NUM_BLOCKS
// entries, with busy high; register writes on the cfg port are taken at any
// time, heap_base resets to 0 and block_count to 1024.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     request_bytes,
  input  logic                            cfg_write,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [ffba_pkg::ADDR_W-1:0]     address,
  output logic [ffba_pkg::FIRST_W-1:0]    first_block
);
  import ffba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [31:0]         heap_base;
  logic [BCOUNT_W-1:0] block_count;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  status_t             status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= '0;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEAP_BASE:   heap_base   <= cfg_data;
        REG_BLOCK_COUNT: block_count <= cfg_data[BCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ffba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffba_seq #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request_bytes (request_bytes),
    .heap_base     (heap_base),
    .block_count   (block_count),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .done          (done),
    .status        (status_q),
    .address       (address),
    .first_block   (first_block)
  );

  assign status = status_q;

endmodule

/* sv/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ffba_table #(
  parameter int NUM_BLOCKS = 1024,
  parameter int IDX_W      = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output ffba_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  ffba_pkg::entry_t     wr_data
);
  import ffba_pkg::*;

  entry_t mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ffba_seq.sv */
// ----------------------------------------------------------------------------
// ffba_seq
// Allocation sequencer: table clearing pass, first-fit scan through one
// shared run-length add and compare unit, run marking and result assembly.
// ----------------------------------------------------------------------------
module ffba_seq #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   request_bytes,
  input  logic [31:0]                   heap_base,
  input  logic [ffba_pkg::BCOUNT_W-1:0] block_count,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  ffba_pkg::entry_t              rd_data,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output ffba_pkg::entry_t              wr_data,
  output logic                          done,
  output ffba_pkg::status_t             status,
  output logic [ffba_pkg::ADDR_W-1:0]   address,
  output logic [ffba_pkg::FIRST_W-1:0]  first_block
);
  import ffba_pkg::*;

  localparam int CMP_W = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
  localparam logic [CMP_W-1:0] NB_CMP   = CMP_W'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [32:0]      BB_RUN   = 33'(BLOCK_BYTES);
  localparam logic [31:0]      BB_ADDR  = 32'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [31:0]      bytes;
  logic [32:0]      run_bytes;
  logic [32:0]      run_sum;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] active;
  logic [CMP_W-1:0] bc_cmp;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic [IDX_W-1:0] run_start;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] wr_ptr;
  logic [31:0]      prod;
  logic             is_free;
  logic             hit;
  logic             can_issue;

  always_comb begin
    bc_cmp    = CMP_W'(block_count);
    active    = (bc_cmp > NB_CMP) ? CNT_W'(NUM_BLOCKS) : CNT_W'(block_count);
    is_free   = entry_free(rd_data);
    run_sum   = run_bytes + BB_RUN;
    hit       = chk_vld && is_free && (run_sum >= {1'b0, bytes});
    can_issue = scan_idx < active;
    busy      = state != S_IDLE;
    rd_en     = (state == S_SCAN) && !hit && can_issue;
    rd_addr   = scan_idx[IDX_W-1:0];
    wr_en     = (state == S_CLEAR) || (state == S_WRITE);
    wr_addr   = wr_ptr;
    wr_data   = '0;
    if (state == S_WRITE) begin
      wr_data = ENTRY_TAKEN;
      if (wr_ptr == run_start) begin
        wr_data = wr_data | ENTRY_FIRST;
      end
      if (wr_ptr != last) begin
        wr_data = wr_data | ENTRY_HAS_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      wr_ptr  <= '0;
      done    <= 1'b0;
      chk_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          wr_ptr <= wr_ptr + 1'b1;
          if (wr_ptr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            bytes <= request_bytes;
            if (request_bytes == '0) begin
              status      <= ST_ZERO_SIZE;
              address     <= '0;
              first_block <= '0;
              done        <= 1'b1;
            end else begin
              scan_idx  <= '0;
              run_bytes <= '0;
              chk_vld   <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld) begin
            if (!is_free) begin
              run_bytes <= '0;
            end else begin
              if (run_bytes == '0) begin
                run_start <= chk_idx;
              end
              run_bytes <= run_sum;
            end
          end
          chk_vld <= rd_en;
          chk_idx <= rd_addr;
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (hit) begin
            last   <= chk_idx;
            wr_ptr <= (run_bytes == '0) ? chk_idx : run_start;
            state  <= S_WRITE;
          end else if (!chk_vld && !can_issue) begin
            status      <= ST_NO_ROOM;
            address     <= '0;
            first_block <= '0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_WRITE: begin
          prod   <= 32'(run_start) * BB_ADDR;
          wr_ptr <= wr_ptr + 1'b1;
          if (wr_ptr == last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          status      <= ST_GRANTED;
          address     <= heap_base + prod;
          first_block <= FIRST_W'(run_start);
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
